### rtl/core/chmu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmu_pkg
// Shared constants, the arctangent table and types of the compass heading and
// magnitude unit.
// ----------------------------------------------------------------------------
package chmu_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int SAMPLE_BITS_DEF  = 16;

	localparam int FIELD_W = 16;
	localparam int HEAD_W  = 13;
	localparam int MAG_W   = 16;
	localparam int SEC_W   = 3;

	// Angles are held in units of 2^-20 degree.
	localparam int ANG_FRAC   = 20;
	localparam int ANG_W      = 31;
	localparam int GUARD_BITS = 8;
	localparam int TABLE_LEN  = 24;
	localparam int TAB_W      = 26;

	localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058, 26'd1876857,
		26'd938658,   26'd469357,   26'd234682,   26'd117342,  26'd58671,   26'd29335,
		26'd14668,    26'd7334,     26'd3667,     26'd1833,    26'd917,     26'd458,
		26'd229,      26'd115,      26'd57,       26'd29,      26'd14,      26'd7
	};

	localparam logic signed [ANG_W-1:0] DEG180 = 31'sd188743680;
	localparam logic signed [ANG_W-1:0] DEG360 = 31'sd377487360;

	localparam logic [HEAD_W-1:0] HD_0   = 13'd0;
	localparam logic [HEAD_W-1:0] HD_90  = 13'd1440;
	localparam logic [HEAD_W-1:0] HD_180 = 13'd2880;
	localparam logic [HEAD_W-1:0] HD_270 = 13'd4320;

	// Sector boundaries in 1/16 degree: the first at 22.5 degrees, then every 45.
	localparam int SEC_FIRST = 360;
	localparam int SEC_SPAN  = 720;
	localparam int SEC_COUNT = 8;

	localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

	// Heading settled before the rotations, for samples that lie on an axis.
	typedef struct packed {
		logic              fixed;
		logic [HEAD_W-1:0] hd;
	} chmu_axis_t;

endpackage
`default_nettype wire

### rtl/core/chmu_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmu_if
// Sample and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface chmu_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] field_x;
	logic [15:0] field_y;
	logic [15:0] field_z;

	modport source (output valid, field_x, field_y, field_z, input ready);
	modport sink (input valid, field_x, field_y, field_z, output ready);
endinterface

interface chmu_out_if;
	logic        valid;
	logic        ready;
	logic [12:0] heading_deg16;
	logic [15:0] field_magnitude;
	logic [2:0]  sector;

	modport source (output valid, heading_deg16, field_magnitude, sector, input ready);
	modport sink (input valid, heading_deg16, field_magnitude, sector, output ready);
endinterface
`default_nettype wire

### rtl/core/chmu_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmu_cordic
// Vectoring CORDIC, one rotation per pipeline stage, giving atan2(y, x).
// ----------------------------------------------------------------------------
module chmu_cordic import chmu_pkg::*; #(
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int CORE         = 17
) (
	input  wire logic                          clk,
	input  wire logic [CORE:0]                 en,
	input  wire logic signed [SAMPLE_BITS-1:0] x_in,
	input  wire logic signed [SAMPLE_BITS-1:0] y_in,
	output logic signed [ANG_W-1:0]            z_out,
	output chmu_axis_t                         axis_out
);

	localparam int SW = SAMPLE_BITS;
	localparam int XW = SW + GUARD_BITS + 3;
	localparam int NC = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	logic signed [XW-1:0]    x_s [CORE+1];
	logic signed [XW-1:0]    y_s [CORE+1];
	logic signed [ANG_W-1:0] z_s [CORE+1];
	chmu_axis_t              a_s [CORE+1];

	logic signed [XW-1:0] xe, ye;
	chmu_axis_t           axis_c;

	always_comb begin
		xe = XW'(x_in) <<< GUARD_BITS;
		ye = XW'(y_in) <<< GUARD_BITS;
		axis_c.fixed = 1'b1;
		if (y_in == '0) begin
			axis_c.hd = x_in[SW-1] ? HD_180 : HD_0;
		end else if (x_in == '0) begin
			axis_c.hd = y_in[SW-1] ? HD_270 : HD_90;
		end else begin
			axis_c.fixed = 1'b0;
			axis_c.hd    = HD_0;
		end
	end

	// Vectors in the left half plane are first turned through 180 degrees.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s[0] <= axis_c;
			if (x_in[SW-1]) begin
				x_s[0] <= -xe;
				y_s[0] <= -ye;
				z_s[0] <= DEG180;
			end else begin
				x_s[0] <= xe;
				y_s[0] <= ye;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= CORE; k++) begin : g_stage
		if (k <= NC) begin : g_rot
			localparam int I = k - 1;
			logic signed [XW-1:0]    dx, dy;
			logic signed [ANG_W-1:0] da;
			always_comb begin
				dx = y_s[k-1] >>> I;
				dy = x_s[k-1] >>> I;
				da = signed'(ANG_W'(ATAN_TAB[I]));
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					a_s[k] <= a_s[k-1];
					if (!y_s[k-1][XW-1]) begin
						x_s[k] <= x_s[k-1] + dx;
						y_s[k] <= y_s[k-1] - dy;
						z_s[k] <= z_s[k-1] + da;
					end else begin
						x_s[k] <= x_s[k-1] - dx;
						y_s[k] <= y_s[k-1] + dy;
						z_s[k] <= z_s[k-1] - da;
					end
				end
			end
		end else begin : g_delay
			always_ff @(posedge clk) begin
				if (en[k]) begin
					a_s[k] <= a_s[k-1];
					x_s[k] <= x_s[k-1];
					y_s[k] <= y_s[k-1];
					z_s[k] <= z_s[k-1];
				end
			end
		end
	end

	assign z_out    = z_s[CORE];
	assign axis_out = a_s[CORE];

endmodule
`default_nettype wire

### rtl/core/chmu_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chmu_sqrt
// Sum of squares and a pipelined restoring square root, one root bit a stage.
// ----------------------------------------------------------------------------
module chmu_sqrt import chmu_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CORE        = 17
) (
	input  wire logic                          clk,
	input  wire logic [CORE:0]                 en,
	input  wire logic signed [SAMPLE_BITS-1:0] x_in,
	input  wire logic signed [SAMPLE_BITS-1:0] y_in,
	input  wire logic signed [SAMPLE_BITS-1:0] z_in,
	output logic [SAMPLE_BITS-1:0]             root_out
);

	localparam int R     = SAMPLE_BITS;
	localparam int RAD_W = 2 * R;
	localparam int REM_W = R + 3;

	logic [R-1:0]     ax, ay, az;
	logic [RAD_W-1:0] sqx_s0, sqy_s0, sqz_s0;

	logic [RAD_W-1:0] rad_s  [CORE+1];
	logic [REM_W-1:0] rem_s  [CORE+1];
	logic [R-1:0]     root_s [CORE+1];

	always_comb begin
		ax = x_in[R-1] ? R'(~x_in + 1'b1) : R'(x_in);
		ay = y_in[R-1] ? R'(~y_in + 1'b1) : R'(y_in);
		az = z_in[R-1] ? R'(~z_in + 1'b1) : R'(z_in);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sqx_s0 <= RAD_W'(ax) * RAD_W'(ax);
			sqy_s0 <= RAD_W'(ay) * RAD_W'(ay);
			sqz_s0 <= RAD_W'(az) * RAD_W'(az);
		end
	end

	// The three squares cannot carry out of the radicand width.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			rad_s[1]  <= sqx_s0 + sqy_s0 + sqz_s0;
			rem_s[1]  <= '0;
			root_s[1] <= '0;
		end
	end

	for (genvar k = 2; k <= CORE; k++) begin : g_stage
		if (k - 2 < R) begin : g_bit
			logic [REM_W-1:0] rem_sh;
			logic [REM_W:0]   trial;
			always_comb begin
				rem_sh = {rem_s[k-1][REM_W-3:0], rad_s[k-1][RAD_W-1 -: 2]};
				trial  = {1'b0, rem_sh} - (REM_W + 1)'({root_s[k-1], 2'b01});
			end
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rad_s[k] <= rad_s[k-1] << 2;
					if (!trial[REM_W]) begin
						rem_s[k]  <= trial[REM_W-1:0];
						root_s[k] <= {root_s[k-1][R-2:0], 1'b1};
					end else begin
						rem_s[k]  <= rem_sh;
						root_s[k] <= {root_s[k-1][R-2:0], 1'b0};
					end
				end
			end
		end else begin : g_delay
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rad_s[k]  <= rad_s[k-1];
					rem_s[k]  <= rem_s[k-1];
					root_s[k] <= root_s[k-1];
				end
			end
		end
	end

	assign root_out = root_s[CORE];

endmodule
`default_nettype wire

### rtl/core/compass_heading_magnitude_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_magnitude_unit
// Compass heading, eight-way sector and field magnitude of one magnetometer
// sample, through a fully pipelined CORDIC and square root.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while results are taken; the depth is set by
// the square root, one root bit per stage, or by the CORDIC, one rotation per
// stage.
// A stalled result holds its stage while bubbles further up still close in.
// Reset clears only the stage valid bits; the data registers are not reset.
module compass_heading_magnitude_unit import chmu_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	chmu_in_if.sink     sample,
	chmu_out_if.source  result
);

	localparam int SW    = SAMPLE_BITS;
	localparam int NC    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int CORE  = (NC > SW + 1) ? NC : SW + 1;
	localparam int L     = CORE + 3;
	localparam int EXT_W = (SW > FIELD_W) ? SW : FIELD_W;

	logic [L-1:0] v_q;
	logic [L-1:0] en;

	logic [EXT_W-1:0]       wx, wy, wz;
	logic signed [SW-1:0]   x_s0, y_s0, z_s0;
	logic signed [ANG_W-1:0] z_ang;
	chmu_axis_t             axis;
	logic [SW-1:0]          root;

	logic signed [ANG_W-1:0] zw;
	logic [HEAD_W-1:0]       hd;
	logic [3:0]              sec_cnt;
	logic [31:0]             root_x;
	logic [MAG_W-1:0]        mag;

	logic [HEAD_W-1:0] heading_q;
	logic [MAG_W-1:0]  mag_q;
	logic [SEC_W-1:0]  sector_q;

	// A stage moves on when it is empty or its successor moves on.
	always_comb begin
		en[L-1] = !v_q[L-1] || result.ready;
		for (int i = L - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < L; i++) begin
				if (en[i]) begin
					v_q[i] <= (i == 0) ? sample.valid : v_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	// Fields are read as two's complement values of SAMPLE_BITS bits.
	always_comb begin
		wx = EXT_W'(sample.field_x);
		wy = EXT_W'(sample.field_y);
		wz = EXT_W'(sample.field_z);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s0 <= signed'(wx[SW-1:0]);
			y_s0 <= signed'(wy[SW-1:0]);
			z_s0 <= signed'(wz[SW-1:0]);
		end
	end

	chmu_cordic #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS),
		.CORE        (CORE)
	) u_cordic (
		.clk     (clk),
		.en      (en[CORE+1:1]),
		.x_in    (x_s0),
		.y_in    (y_s0),
		.z_out   (z_ang),
		.axis_out(axis)
	);

	chmu_sqrt #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.CORE       (CORE)
	) u_sqrt (
		.clk     (clk),
		.en      (en[CORE+1:1]),
		.x_in    (x_s0),
		.y_in    (y_s0),
		.z_in    (z_s0),
		.root_out(root)
	);

	// The CORDIC angle stays within -100 and 280 degrees, so one wrap suffices.
	always_comb begin
		zw = z_ang[ANG_W-1] ? z_ang + DEG360 : z_ang;
		hd = axis.fixed ? axis.hd : zw[ANG_FRAC-4 +: HEAD_W];
		sec_cnt = '0;
		for (int k = 0; k < SEC_COUNT; k++) begin
			if (hd >= HEAD_W'(SEC_FIRST + k * SEC_SPAN)) begin
				sec_cnt = sec_cnt + 4'd1;
			end
		end
		root_x = 32'(root);
		mag    = (root_x > 32'(MAG_MAX)) ? MAG_MAX : root_x[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[L-1]) begin
			heading_q <= hd;
			mag_q     <= mag;
			sector_q  <= sec_cnt[SEC_W-1:0];
		end
	end

	assign sample.ready           = en[0];
	assign result.valid           = v_q[L-1];
	assign result.heading_deg16   = heading_q;
	assign result.field_magnitude = mag_q;
	assign result.sector          = sector_q;

endmodule
`default_nettype wire
